FILE: src/atdds_pkg.sv
package atdds_pkg;

    // Field widths of the stream payload
    localparam int SAMPLE_W  = 12;
    localparam int MEAN_W    = 12;
    localparam int STEP_W    = 10;
    localparam int INDEX_W   = 12;

    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

    // Packed bus widths, rounded up to whole bytes
    localparam int S_TDATA_W = 16;
    localparam int S_PAD_W   = S_TDATA_W - SAMPLE_W;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - INDEX_W - MEAN_W - STEP_W;

    // Default geometry
    localparam int HISTORY_DEPTH_DEF = 8;
    localparam int PHASE_BITS_DEF    = 16;
    localparam int INDEX_BITS_DEF    = 12;

    // Phase step derivation
    localparam int                STEP_SHIFT = 2;
    localparam logic [STEP_W-1:0] STEP_MIN   = 10'd1;
    localparam logic [STEP_W-1:0] STEP_MAX   = 10'd999;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    // Per-transaction status handed from the averaging stages to the accumulator
    typedef struct packed {
        op_t               op;
        logic [MEAN_W-1:0] mean;
        logic [STEP_W-1:0] step;
    } step_info_t;

    // Mean shifted down and clamped into the legal step range
    function automatic logic [STEP_W-1:0] clamp_step(input logic [MEAN_W-1:0] mean);
        logic [MEAN_W-STEP_SHIFT-1:0] q;
        q = mean[MEAN_W-1:STEP_SHIFT];
        if (q == '0) begin
            return STEP_MIN;
        end else if (STEP_W'(q) > STEP_MAX) begin
            return STEP_MAX;
        end else begin
            return STEP_W'(q);
        end
    endfunction

endpackage

FILE: src/atdds_cell.sv
module atdds_cell import atdds_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                shift_en,
    input  logic [SAMPLE_W-1:0] d_in,
    output logic [SAMPLE_W-1:0] q_out
);

    logic [SAMPLE_W-1:0] value_reg;

    // Take the neighbor's sample on each shift, clear on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
        end else if (shift_en) begin
            value_reg <= d_in;
        end
    end

    assign q_out = value_reg;

endmodule

FILE: src/atdds_mean.sv
module atdds_mean import atdds_pkg::*; #(
    parameter  int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    localparam int SUM_W         = SAMPLE_W + $clog2(HISTORY_DEPTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  op_t              in_op,
    input  logic [SUM_W-1:0] in_sum,
    output logic             out_valid,
    input  logic             out_ready,
    output step_info_t       out_info
);

    // Exact floor division by the depth: multiply by a rounded-up reciprocal
    localparam int          LOG_D      = $clog2(HISTORY_DEPTH);
    localparam int          SHIFT      = SUM_W + LOG_D;
    localparam int          PROD_W     = 2 * SUM_W + 1;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
    localparam logic [SUM_W:0] RECIP   = RECIP_FULL[SUM_W:0];

    logic              b_valid_reg;
    op_t               b_op_reg;
    logic [PROD_W-1:0] b_prod_reg;
    logic [PROD_W-1:0] b_prod_next;
    logic              b_ready;

    logic              c_valid_reg;
    step_info_t        c_info_reg;
    step_info_t        c_info_next;
    logic              c_ready;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign in_ready = b_ready;

    assign b_prod_next = PROD_W'(in_sum) * PROD_W'(RECIP);

    // Quotient out of the product, then derive the step
    always_comb begin
        c_info_next.op   = b_op_reg;
        c_info_next.mean = b_prod_reg[SHIFT +: MEAN_W];
        c_info_next.step = clamp_step(c_info_next.mean);
    end

    // Advance the two stages, holding whatever is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (b_ready) begin
                b_valid_reg <= in_valid;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
        end
        if (b_ready && in_valid) begin
            b_op_reg   <= in_op;
            b_prod_reg <= b_prod_next;
        end
        if (c_ready && b_valid_reg) begin
            c_info_reg <= c_info_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_info  = c_info_reg;

endmodule

FILE: src/adc_tuned_dds_phase_accumulator_unit.sv
// ADC-tuned DDS phase accumulator. Each input transaction is either a 12-bit
// converter sample (tuser 0) or one DDS output tick (tuser 1), and each gives
// exactly one result: the waveform table index (top INDEX_BITS of the phase
// accumulator, cut or zero-extended to 12 bits), the mean of the last
// HISTORY_DEPTH samples and the phase step (mean / 4, clamped to 1..999).
// Samples shift through a row of HISTORY_DEPTH cells that reset to zero; a
// running sum tracks the row and is divided by the depth through a
// reciprocal multiply. The block takes one transaction every clock while the
// pipeline is not stalled. The edge that takes a transaction loads the sum
// register; the transaction then passes the product register, the mean and
// step register behind the clamp, and the output register.
// A stalled output holds the pipeline only where it is full.
module adc_tuned_dds_phase_accumulator_unit import atdds_pkg::*; #(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int PHASE_BITS    = PHASE_BITS_DEF,
    parameter int INDEX_BITS    = INDEX_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [11:0] sample, [15:12] zero
    input  logic                 s_tuser,   // [0] op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [11:0] table_index, [23:12] average,
                                            // [33:24] phase_step, [39:34] zero
);

    localparam int SUM_W = SAMPLE_W + $clog2(HISTORY_DEPTH);

    logic                s_accept;
    op_t                 s_op;
    logic [SAMPLE_W-1:0] s_sample;
    logic                shift_en;
    logic [SAMPLE_W-1:0] cell_q [HISTORY_DEPTH];

    logic                a_valid_reg;
    op_t                 a_op_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic                mean_in_ready;

    logic                c_valid;
    step_info_t          c_info;
    logic                c_take;
    logic                d_ready;

    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [INDEX_BITS-1:0] index_full;
    logic [INDEX_W-1:0]    index_out;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    assign s_op     = op_t'(s_tuser);
    assign s_sample = s_tdata[SAMPLE_W-1:0];
    assign s_tready = !a_valid_reg || mean_in_ready;
    assign s_accept = s_tvalid && s_tready;
    assign shift_en = s_accept && (s_op == OP_SAMPLE);

    // Sample history: a row of cells, newest at the head, oldest falls off the end
    for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
        logic [SAMPLE_W-1:0] d_in;
        if (i == 0) begin : g_head
            assign d_in = s_sample;
        end else begin : g_link
            assign d_in = cell_q[i-1];
        end
        atdds_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .d_in     (d_in),
            .q_out    (cell_q[i])
        );
    end

    // Running sum: add the new sample, drop the one leaving the row
    assign sum_next = sum_reg + SUM_W'(s_sample) - SUM_W'(cell_q[HISTORY_DEPTH-1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            sum_reg     <= '0;
        end else begin
            if (s_tready) begin
                a_valid_reg <= s_tvalid;
            end
            if (shift_en) begin
                sum_reg <= sum_next;
            end
        end
        if (s_accept) begin
            a_op_reg <= s_op;
        end
    end

    atdds_mean #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_mean (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (a_valid_reg),
        .in_ready  (mean_in_ready),
        .in_op     (a_op_reg),
        .in_sum    (sum_reg),
        .out_valid (c_valid),
        .out_ready (d_ready),
        .out_info  (c_info)
    );

    // Advance the phase on a tick, hold it on a sample
    assign d_ready    = !m_tvalid_reg || m_tready;
    assign c_take     = c_valid && d_ready;
    assign phase_next = (c_info.op == OP_TICK) ? phase_reg + PHASE_BITS'(c_info.step)
                                                : phase_reg;
    assign index_full = phase_next[PHASE_BITS-1 -: INDEX_BITS];
    assign index_out  = INDEX_W'(index_full);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            phase_reg    <= '0;
        end else begin
            if (d_ready) begin
                m_tvalid_reg <= c_valid;
            end
            if (c_take) begin
                phase_reg <= phase_next;
            end
        end
        if (c_take) begin
            m_tdata_reg <= {{M_PAD_W{1'b0}}, c_info.step, c_info.mean, index_out};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Result step always agrees with the result mean
    a_step_matches_mean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata_reg[INDEX_W+MEAN_W +: STEP_W]
                     == clamp_step(m_tdata_reg[INDEX_W +: MEAN_W]))
        else $error("phase_step does not match average");

    // Running sum never exceeds a full row of maximum samples
    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |-> {1'b0, sum_reg} <= (SUM_W+1)'(HISTORY_DEPTH * SAMPLE_MAX))
        else $error("running sum out of range");

    // Input is held off only by a full, stalled first stage
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> a_valid_reg && !mean_in_ready)
        else $error("input stalled without cause");

    // A sample transaction leaves the phase untouched
    a_sample_holds_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        c_take && (c_info.op == OP_SAMPLE) |=> $stable(phase_reg))
        else $error("phase moved on a sample");

endmodule

FILE: tb/tb_adc_tuned_dds_phase_accumulator_unit.sv
`timescale 1ns / 1ps

module tb_adc_tuned_dds_phase_accumulator_unit;
    import atdds_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 100000;
    localparam int RANDOM_ITEMS = 650;
    localparam int SETTLE_CYCLES = 20;
    localparam int IDLE_PCT    = 15;

    // One result word split into its fields
    typedef struct packed {
        logic [STEP_W-1:0]  step;
        logic [MEAN_W-1:0]  mean;
        logic [INDEX_W-1:0] index;
    } phase_word_t;

    // Tracks the sample ring, the tuning step and the phase, and checks results
    class tuning_tracker;
        logic [SAMPLE_W-1:0]       ring [HISTORY_DEPTH_DEF];
        int unsigned               wr_ptr;
        logic [MEAN_W-1:0]         mean;
        logic [STEP_W-1:0]         step;
        logic [PHASE_BITS_DEF-1:0] phase;
        phase_word_t               expected_words [$];
        int unsigned               errors;

        function new();
            foreach (ring[i]) ring[i] = '0;
            wr_ptr = 0;
            mean   = '0;
            step   = STEP_MIN;
            phase  = '0;
            errors = 0;
        endfunction

        function int unsigned pending();
            return expected_words.size();
        endfunction

        function void flag(string what, int unsigned want, int unsigned got);
            errors++;
            if (errors <= 10)
                $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
        endfunction

        // Advance the tuning state by one accepted transaction
        function void take_item(op_t op, logic [SAMPLE_W-1:0] sample);
            int unsigned total;
            int unsigned quarter;
            phase_word_t w;
            if (op == OP_SAMPLE) begin
                ring[wr_ptr] = sample;
                wr_ptr = (wr_ptr + 1) % HISTORY_DEPTH_DEF;
                total = 0;
                foreach (ring[i]) total += ring[i];
                mean = MEAN_W'(total / HISTORY_DEPTH_DEF);
                quarter = mean >> STEP_SHIFT;
                if (quarter == 0)
                    step = STEP_MIN;
                else if (quarter > STEP_MAX)
                    step = STEP_MAX;
                else
                    step = STEP_W'(quarter);
            end else begin
                // wrap modulo the accumulator width
                phase = phase + PHASE_BITS_DEF'(step);
            end
            w.index = INDEX_W'(phase >> (PHASE_BITS_DEF - INDEX_BITS_DEF));
            w.mean  = mean;
            w.step  = step;
            expected_words.push_back(w);
        endfunction

        // Compare one result transaction with the oldest prediction
        function void compare_output(logic [M_TDATA_W-1:0] tdata);
            phase_word_t want;
            logic [M_PAD_W-1:0] pad;
            if (expected_words.size() == 0) begin
                flag("unexpected result, index", 0, tdata[INDEX_W-1:0]);
                return;
            end
            want = expected_words.pop_front();
            pad  = tdata[M_TDATA_W-1 -: M_PAD_W];
            if (tdata[INDEX_W-1:0] !== want.index)
                flag("table_index", want.index, tdata[INDEX_W-1:0]);
            if (tdata[INDEX_W +: MEAN_W] !== want.mean)
                flag("average", want.mean, tdata[INDEX_W +: MEAN_W]);
            if (tdata[INDEX_W+MEAN_W +: STEP_W] !== want.step)
                flag("phase_step", want.step, tdata[INDEX_W+MEAN_W +: STEP_W]);
            if (pad !== '0)
                flag("padding", 0, pad);
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    bit            sender_idles   = 1'b1;
    bit            receiver_idles = 1'b1;
    int unsigned   cycle_count    = 0;
    tuning_tracker tracker;

    adc_tuned_dds_phase_accumulator_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_adc_tuned_dds_phase_accumulator_unit NOT OK");
            $finish;
        end
    end

    // Stall the result channel at random
    always @(posedge aclk) begin
        if (receiver_idles && $urandom_range(0, 99) < IDLE_PCT)
            m_tready <= 1'b0;
        else
            m_tready <= 1'b1;
    end

    // Record accepted inputs, then check accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tracker.take_item(op_t'(s_tuser), s_tdata[SAMPLE_W-1:0]);
            if (m_tvalid && m_tready)
                tracker.compare_output(m_tdata);
        end
    end

    // Present one transaction, with random gaps ahead of it, and hold until taken
    task automatic send_item(input op_t op, input logic [SAMPLE_W-1:0] sample);
        while (sender_idles && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{S_PAD_W{1'b0}}, sample};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Hold the sender until every predicted result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        int unsigned sent;
        int unsigned seg;
        int unsigned seg_len;
        int unsigned level;
        int unsigned tick_pct;
        logic [SAMPLE_W-1:0] value;
        op_t op;

        tracker = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Ticks from reset, one carrying a full sample field that must be ignored
        send_item(OP_TICK, '0);
        send_item(OP_TICK, SAMPLE_W'(SAMPLE_MAX));
        // Fill the ring with full scale: the step clamps at its maximum
        repeat (HISTORY_DEPTH_DEF) send_item(OP_SAMPLE, SAMPLE_W'(SAMPLE_MAX));
        send_item(OP_TICK, 12'h555);
        send_item(OP_TICK, 12'haaa);
        // Empty the ring: the step drops to the floor of one
        repeat (HISTORY_DEPTH_DEF) send_item(OP_SAMPLE, '0);
        send_item(OP_SAMPLE, 12'd31);
        send_item(OP_SAMPLE, 12'd32);
        send_item(OP_TICK, '0);
        drain_results();

        // Random segments, each with its own sample level and tick density
        sent = 0;
        seg  = 0;
        while (sent < RANDOM_ITEMS) begin
            seg_len  = (seg == 3) ? 120 : $urandom_range(20, 60);
            level    = $urandom_range(0, 3);
            tick_pct = $urandom_range(20, 85);
            sender_idles   = (seg != 3);
            receiver_idles = (seg != 3);
            repeat (seg_len) begin
                op = ($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_SAMPLE;
                case (level)
                    0: value = SAMPLE_W'($urandom_range(0, 40));
                    1: value = SAMPLE_W'($urandom_range(3800, SAMPLE_MAX));
                    2: value = SAMPLE_W'($urandom_range(1000, 3000));
                    default: value = SAMPLE_W'($urandom);
                endcase
                send_item(op, value);
                sent++;
            end
            if (seg == 6)
                drain_results();
            seg++;
        end
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;

        // Wait out the pipeline, then give a late result time to show
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("tb_adc_tuned_dds_phase_accumulator_unit OK");
        end else begin
            $display("tb_adc_tuned_dds_phase_accumulator_unit NOT OK");
        end
        $finish;
    end

endmodule
